>>> sv/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_NL,
        CMD_PUT,
        CMD_NOP
    } cmd_t;

    localparam logic       OP_PUT       = 1'b0;
    localparam logic       OP_READ      = 1'b1;

    localparam logic [7:0] CHAR_BS      = 8'd8;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NL      = 8'd10;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;
    localparam logic [15:0] SCROLL_BLANK = 16'h0F20;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  char_code;
        logic [10:0] read_index;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

>>> sv/tccw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

>>> sv/tccw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Input side: takes words, decodes the byte class and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tccw_front
    import tccw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_index,
    output q_head_t     head,
    input  back_ctl_t   ctl
);

    localparam int QDEPTH = 2;
    localparam int PW     = $clog2(QDEPTH);
    localparam int NW     = $clog2(QDEPTH + 1);

    q_entry_t        entry_reg [QDEPTH];
    q_entry_t        entry_in;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;
    cmd_t            cmd;

    always_comb
    begin
        if (op == OP_READ)
        begin
            cmd = CMD_READ;
        end
        else
        begin
            case (char_code)
                CHAR_BS:  cmd = CMD_BS;
                CHAR_TAB: cmd = CMD_TAB;
                CHAR_CR:  cmd = CMD_CR;
                CHAR_NL:  cmd = CMD_NL;
                default:  cmd = (char_code >= CHAR_SPACE) ? CMD_PUT : CMD_NOP;
            endcase
        end
        entry_in.cmd        = cmd;
        entry_in.char_code  = char_code;
        entry_in.read_index = read_index;
    end

    assign in_stall   = (count_reg == NW'(QDEPTH)) || ctl.clearing;
    assign push       = in_valid && !in_stall;
    assign pop        = ctl.pop;
    assign head.valid = (count_reg != '0);
    assign head.entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

>>> sv/tccw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Execution side: cursor logic, screen RAM kept as a ring of rows, scroll
// blanking, reset clearing sweep and the output word register.
// ----------------------------------------------------------------------------
module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  q_head_t     head,
    output back_ctl_t   ctl,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [10:0] cursor_index,
    output logic [15:0] cell_data
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int AWP       = AW + 1;
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int TW        = $clog2(TAB_WIDTH);
    localparam int SW        = ((CW > TW) ? CW : TW) + 2;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam logic [AW:0] CELLS_W = AWP'(CELLS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    q_entry_t        cmd_reg, cmd_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [TW-1:0]   phase_reg, phase_next;
    logic [AW-1:0]   lin_reg, lin_next;
    logic [AW-1:0]   top_reg, top_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   blank_addr_reg, blank_addr_next;
    logic            hit_reg, hit_next;
    logic [7:0]      attr_reg, attr_next;
    logic            out_valid_reg, out_valid_next;
    logic [4:0]      cursor_row_reg, cursor_row_next;
    logic [6:0]      cursor_col_reg, cursor_col_next;
    logic [10:0]     cursor_index_reg, cursor_index_next;
    logic [15:0]     cell_data_reg, cell_data_next;

    logic [CW-1:0]   x_col;
    logic [RW-1:0]   x_row;
    logic [TW-1:0]   x_phase;
    logic [AW-1:0]   x_lin;
    logic [AW-1:0]   x_top;
    logic            x_we;
    logic [AW-1:0]   x_wlin;
    logic [15:0]     x_wdata;
    logic            x_newline;
    logic            x_scroll;
    logic            x_read;
    logic [SW-1:0]   tab_col;
    logic [AW-1:0]   lin_row0;
    logic [AW:0]     top_sum;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] lin,
                                              input logic [AW-1:0] base);
        logic [AW:0] sum;
        begin
            sum = {1'b0, lin} + {1'b0, base};
            if (sum >= CELLS_W)
            begin
                sum = sum - CELLS_W;
            end
            return sum[AW-1:0];
        end
    endfunction

    tccw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // cursor update for the word in cmd_reg
    always_comb
    begin
        x_col     = col_reg;
        x_row     = row_reg;
        x_phase   = phase_reg;
        x_lin     = lin_reg;
        x_top     = top_reg;
        x_we      = 1'b0;
        x_wlin    = lin_reg;
        x_wdata   = {attr_reg, cmd_reg.char_code};
        x_newline = 1'b0;
        x_scroll  = 1'b0;
        x_read    = 1'b0;
        tab_col   = SW'(col_reg) + SW'(TAB_WIDTH) - SW'(phase_reg);
        lin_row0  = lin_reg - AW'(col_reg);
        top_sum   = {1'b0, top_reg} + AWP'(COLUMNS);

        case (cmd_reg.cmd)
            CMD_READ:
            begin
                x_read = (int'(cmd_reg.read_index) < CELLS);
            end
            CMD_BS:
            begin
                x_we    = 1'b1;
                x_wdata = {attr_reg, CHAR_SPACE};
                if (col_reg != '0)
                begin
                    x_col   = col_reg - 1'b1;
                    x_lin   = lin_reg - AW'(1);
                    x_wlin  = lin_reg - AW'(1);
                    x_phase = (phase_reg == '0) ? TW'(TAB_WIDTH - 1) : phase_reg - 1'b1;
                end
            end
            CMD_TAB:
            begin
                if (tab_col >= SW'(COLUMNS))
                begin
                    x_newline = 1'b1;
                end
                else
                begin
                    x_col   = CW'(tab_col);
                    x_lin   = lin_reg + AW'(TAB_WIDTH) - AW'(phase_reg);
                    x_phase = '0;
                end
            end
            CMD_CR:
            begin
                x_col   = '0;
                x_phase = '0;
                x_lin   = lin_row0;
            end
            CMD_NL:
            begin
                x_newline = 1'b1;
            end
            CMD_PUT:
            begin
                x_we = 1'b1;
                if (col_reg == CW'(COLUMNS - 1))
                begin
                    x_newline = 1'b1;
                end
                else
                begin
                    x_col   = col_reg + 1'b1;
                    x_lin   = lin_reg + AW'(1);
                    x_phase = (phase_reg == TW'(TAB_WIDTH - 1)) ? '0 : phase_reg + 1'b1;
                end
            end
            default:
            begin
                x_we = 1'b0;
            end
        endcase

        if (x_newline)
        begin
            x_col   = '0;
            x_phase = '0;
            if (row_reg == RW'(ROWS - 1))
            begin
                x_scroll = 1'b1;
                x_lin    = AW'(LAST_BASE);
                x_top    = (top_sum >= CELLS_W) ? '0 : top_sum[AW-1:0];
            end
            else
            begin
                x_row = row_reg + 1'b1;
                x_lin = lin_row0 + AW'(COLUMNS);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        phase_next        = phase_reg;
        lin_next          = lin_reg;
        top_next          = top_reg;
        cnt_next          = cnt_reg;
        blank_addr_next   = blank_addr_reg;
        hit_next          = hit_reg;
        attr_next         = cfg_we ? cfg_wdata : attr_reg;
        out_valid_next    = out_valid_reg && out_stall;
        cursor_row_next   = cursor_row_reg;
        cursor_col_next   = cursor_col_reg;
        cursor_index_next = cursor_index_reg;
        cell_data_next    = cell_data_reg;
        ctl.pop           = 1'b0;
        ctl.clearing      = (state_reg == S_CLEAR);
        ram_we            = 1'b0;
        ram_waddr         = cnt_reg;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = to_phys(AW'(cmd_reg.read_index), top_reg);

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (head.valid && (!out_valid_reg || !out_stall))
                begin
                    ctl.pop    = 1'b1;
                    cmd_next   = head.entry;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                col_next   = x_col;
                row_next   = x_row;
                phase_next = x_phase;
                lin_next   = x_lin;
                top_next   = x_top;
                ram_we     = x_we;
                ram_waddr  = to_phys(x_wlin, top_reg);
                ram_wdata  = x_wdata;
                ram_re     = x_read;
                hit_next   = x_read;
                if (x_scroll)
                begin
                    blank_addr_next = top_reg;
                    cnt_next        = '0;
                    state_next      = S_SCROLL;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCROLL:
            begin
                ram_we          = 1'b1;
                ram_waddr       = blank_addr_reg;
                ram_wdata       = SCROLL_BLANK;
                blank_addr_next = blank_addr_reg + 1'b1;
                if (cnt_reg == AW'(COLUMNS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                out_valid_next    = 1'b1;
                cursor_row_next   = 5'(row_reg);
                cursor_col_next   = 7'(col_reg);
                cursor_index_next = 11'(lin_reg);
                cell_data_next    = hit_reg ? ram_rdata : '0;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            lin_reg       <= '0;
            top_reg       <= '0;
            cnt_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            lin_reg       <= lin_next;
            top_reg       <= top_next;
            cnt_reg       <= cnt_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        blank_addr_reg   <= blank_addr_next;
        hit_reg          <= hit_next;
        cursor_row_reg   <= cursor_row_next;
        cursor_col_reg   <= cursor_col_next;
        cursor_index_reg <= cursor_index_next;
        cell_data_reg    <= cell_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign cursor_row   = cursor_row_reg;
    assign cursor_col   = cursor_col_reg;
    assign cursor_index = cursor_index_reg;
    assign cell_data    = cell_data_reg;

endmodule

>>> sv/text_console_char_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text screen of ROWS x COLUMNS character cells with a cursor.
//
// Input words (in_valid / in_stall): op selects a put of char_code or a read
// of the cell at read_index. Every word gives one output word (out_valid /
// out_stall) with the cursor after the word and, for reads, the cell.
// cfg_we / cfg_wdata write the attribute byte; write it only while idle.
// An accepted word passes the states EXEC and RESP before out_valid; a word
// that scrolls the screen also passes SCROLL, which blanks the new bottom row
// one cell per cycle through the single write port of the screen RAM. The
// back end takes a new word only when it is done with the last. Rows live in
// the RAM as a ring, so a scroll moves the top-row pointer instead of rows.
// A two-entry queue sits behind in_stall, so words are still taken while an
// output word is held by out_stall; the output word is held stable until
// taken. After reset in_stall stays high while all ROWS * COLUMNS cells of
// the screen RAM are swept to zero; the cursor is at row 0, column 0 and the
// attribute is 0x0F.
// ----------------------------------------------------------------------------
module text_console_char_writer_top
    import tccw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [10:0] cursor_index,
    output logic [15:0] cell_data,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    q_head_t   head;
    back_ctl_t ctl;

    tccw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .read_index (read_index),
        .head       (head),
        .ctl        (ctl)
    );

    tccw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .ctl          (ctl),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .cursor_index (cursor_index),
        .cell_data    (cell_data)
    );

endmodule

>>> sv/tccw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks of the text console character writer, bound to the top.
// ----------------------------------------------------------------------------
module tccw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_col,
    input logic [10:0] cursor_index,
    input logic [15:0] cell_data
);

    // held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_index) && $stable(cell_data))
        else $error("output word changed while stalled");

    // screen sweep keeps input closed right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("input open during reset sweep");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ROWS > 32) || (COLUMNS > 128) ||
            (cursor_index == 11'(cursor_row * COLUMNS + cursor_col)))
        else $error("cursor index does not match row and column");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((ROWS > 32) || (int'(cursor_row) < ROWS)) &&
            ((COLUMNS > 128) || (int'(cursor_col) < COLUMNS)))
        else $error("cursor outside the screen");

endmodule

bind text_console_char_writer_top tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .cursor_index (cursor_index),
    .cell_data    (cell_data)
);
